>>> rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the fit policy block allocator
// table geometry, request/result structs, status and kind codes
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MaxBlocks  = 64;
  localparam int IdxW       = $clog2(MaxBlocks);
  localparam int CntW       = IdxW + 1;
  localparam int PageBytes  = 4096;
  localparam int PageShift  = $clog2(PageBytes);
  localparam int MaxPages   = 4096;
  localparam int AddrW      = 24;
  localparam int SizeW      = 25;
  localparam logic [SizeW-1:0] PoolLimit = SizeW'(1) << AddrW;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TBL_FULL  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_PAGES  = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] address;
  } fba_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] block_address;
    logic             block_valid;
    logic [SizeW-1:0] block_size;
    logic [SizeW-1:0] largest_gap;
    logic [SizeW-1:0] free_bytes;
  } fba_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_GAP_RD,
    S_GAP,
    S_DONE
  } fsm_t;

  // memory port requests from the sequencer
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [AddrW-1:0] wstart;
    logic [SizeW-1:0] wlen;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

endpackage

>>> rtl/fba_table.sv
// ----------------------------------------------------------------------------
// fba_table: block table memory
// one write port and one registered read port, start and length per entry
// ----------------------------------------------------------------------------
module fba_table
  import fba_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [AddrW-1:0] rd_start,
  output logic [SizeW-1:0] rd_len
);

  logic [AddrW-1:0] start_mem [MaxBlocks];
  logic [SizeW-1:0] len_mem   [MaxBlocks];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      start_mem[req.waddr] <= req.wstart;
      len_mem[req.waddr]   <= req.wlen;
    end
    rd_start <= start_mem[req.raddr];
    rd_len   <= len_mem[req.raddr];
  end

endmodule

>>> rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first/best/worst fit block allocator
// address-sorted table of blocks, entries visited in turn by a read and check cycle
// ----------------------------------------------------------------------------
// channel | ports                         | handshake
// request | start, busy, in_req           | taken when start & !busy
// result  | out_valid, out_rsp            | one cycle strobe, no stall
// config  | cfg_valid/ready, cfg_index/.. | written when valid & ready
//
// a search walk and a gap walk each read a slot (S_SCAN_RD, S_GAP_RD)
// and then check it (S_SCAN, S_GAP); insert and remove move entries one
// at a time through S_SHIFT_RD and S_SHIFT_WR. the strobe is registered
// in S_DONE. the single registered table read port sets this order.
// a shared gap unit walks the entries; a final walk finds the
// largest gap. reset empties the table, no clearing pass is needed.
// config is taken only while idle.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
  import fba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fba_req_t         in_req,
  output logic             out_valid,
  output fba_rsp_t         out_rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [12:0]      cfg_data
);

  fsm_t state_r, state_nxt;
  logic [1:0]       policy_r;
  logic [SizeW-1:0] pool_r, free_r;
  logic [CntW-1:0]  cnt_r;
  fba_req_t         req_r;
  logic [CntW-1:0]  i_r;
  logic [AddrW:0]   prev_end_r;   // end of previous block
  logic             found_r;
  logic [CntW-1:0]  chosen_r;
  logic [SizeW-1:0] cgap_r;
  logic [AddrW-1:0] clo_r;
  logic [SizeW-1:0] bsize_r, lgap_r;
  logic [1:0]       status_r;
  logic             valid_r;
  logic [AddrW-1:0] baddr_r;
  logic [CntW-1:0]  j_r;          // shift pointer
  logic             ins_r;        // shift direction: up for insert

  logic [AddrW-1:0] rd_start;
  logic [SizeW-1:0] rd_len;
  mem_req_t         mreq;

  fba_table u_table (.clk(clk), .req(mreq), .rd_start(rd_start), .rd_len(rd_len));

  // shared gap unit: gap before entry i (or end gap at i==cnt)
  logic             at_end;
  logic [AddrW:0]   hi_v;
  logic [SizeW-1:0] gap_v;
  logic [AddrW:0]   blk_end;
  logic             hit_v;
  always_comb begin
    at_end  = (i_r == cnt_r);
    hi_v    = at_end ? pool_r : {1'b0, rd_start};
    gap_v   = (hi_v > prev_end_r) ? SizeW'(hi_v - prev_end_r) : '0;
    blk_end = {1'b0, rd_start} + rd_len;
    hit_v   = (rd_start <= req_r.address) && ({1'b0, req_r.address} < blk_end);
  end

  // page count to bytes
  logic [12:0]      pg;
  logic [SizeW-1:0] pool_v;
  always_comb begin
    pg = (cfg_data == '0) ? 13'd1 : cfg_data;
    if (pg > 13'(MaxPages)) pg = 13'(MaxPages);
    pool_v = (SizeW'(pg) << PageShift > PoolLimit) ? PoolLimit : SizeW'(pg) << PageShift;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (req_r.kind == KIND_ALLOC) begin
          if (cnt_r == CntW'(MaxBlocks) || req_r.request_size == '0 ||
              req_r.request_size > free_r) state_nxt = S_GAP_RD;
          else if (at_end || (gap_v >= req_r.request_size && !found_r &&
                   policy_r != POL_BEST && policy_r != POL_WORST)) begin
            if (found_r || gap_v >= req_r.request_size) state_nxt = S_SHIFT_RD;
            else state_nxt = S_GAP_RD;
          end else state_nxt = S_SCAN_RD;
        end else if (req_r.kind == KIND_NOP || at_end) state_nxt = S_GAP_RD;
        else if (hit_v) state_nxt = (req_r.kind == KIND_FREE) ? S_SHIFT_RD : S_GAP_RD;
        else state_nxt = S_SCAN_RD;
      end
      S_SHIFT_RD: begin
        if (ins_r ? (j_r == chosen_r) : (j_r == cnt_r)) state_nxt = ins_r ? S_INS : S_GAP_RD;
        else state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_INS:      state_nxt = S_GAP_RD;
      S_GAP_RD:   state_nxt = S_GAP;
      S_GAP:      state_nxt = at_end ? S_DONE : S_GAP_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mreq = '0;
    mreq.raddr = i_r[IdxW-1:0];
    unique case (state_r)
      S_SHIFT_RD: mreq.raddr = ins_r ? IdxW'(j_r - 1'b1) : j_r[IdxW-1:0];
      S_SHIFT_WR: begin
        mreq.we     = 1'b1;
        mreq.waddr  = ins_r ? j_r[IdxW-1:0] : IdxW'(j_r - 1'b1);
        mreq.wstart = rd_start;
        mreq.wlen   = rd_len;
      end
      S_INS: begin
        mreq.we     = 1'b1;
        mreq.waddr  = chosen_r[IdxW-1:0];
        mreq.wstart = clo_r;
        mreq.wlen   = req_r.request_size;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= POL_FIRST;
      pool_r   <= SizeW'(PageBytes);
      free_r   <= SizeW'(PageBytes);
      cnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_POLICY) policy_r <= cfg_data[1:0];
            else begin
              pool_r <= pool_v;
              free_r <= pool_v;
              cnt_r  <= '0;
            end
          end
          if (start) begin
            req_r      <= in_req;
            i_r        <= '0;
            prev_end_r <= '0;
            found_r    <= 1'b0;
            status_r   <= ST_OK;
            valid_r    <= 1'b0;
            baddr_r    <= '0;
            bsize_r    <= '0;
            if (in_req.kind == KIND_FREE || in_req.kind == KIND_LOOKUP)
              status_r <= ST_NOT_FOUND;
          end
        end
        S_SCAN: begin
          if (req_r.kind == KIND_ALLOC) begin
            if (cnt_r == CntW'(MaxBlocks)) status_r <= ST_TBL_FULL;
            else if (req_r.request_size == '0 || req_r.request_size > free_r)
              status_r <= ST_NO_SPACE;
            else begin
              // fit test and policy compare
              if (gap_v >= req_r.request_size && (!found_r ||
                  (policy_r == POL_BEST && gap_v < cgap_r) ||
                  (policy_r == POL_WORST && gap_v > cgap_r))) begin
                found_r  <= 1'b1;
                chosen_r <= i_r;
                cgap_r   <= gap_v;
                clo_r    <= prev_end_r[AddrW-1:0];
              end
              if (state_nxt == S_SHIFT_RD) begin
                ins_r <= 1'b1;
                j_r   <= cnt_r;
                if (!(found_r)) begin
                  chosen_r <= i_r;
                  clo_r    <= prev_end_r[AddrW-1:0];
                end
              end else if (state_nxt == S_GAP_RD) status_r <= ST_NO_SPACE;
              prev_end_r <= blk_end;
              i_r        <= i_r + 1'b1;
            end
          end else if (req_r.kind != KIND_NOP && !at_end) begin
            if (hit_v) begin
              status_r <= ST_OK;
              valid_r  <= (req_r.kind == KIND_LOOKUP);
              bsize_r  <= (req_r.kind == KIND_LOOKUP) ? rd_len : '0;
              if (req_r.kind == KIND_FREE) begin
                free_r <= free_r + rd_len;
                ins_r  <= 1'b0;
                j_r    <= i_r + 1'b1;
              end
            end
            i_r <= i_r + 1'b1;
          end
          if (state_nxt == S_GAP_RD) begin
            i_r        <= '0;
            prev_end_r <= '0;
            lgap_r     <= '0;
          end
        end
        S_SHIFT_RD: begin
          if (state_nxt == S_GAP_RD) begin
            cnt_r      <= cnt_r - 1'b1;
            i_r        <= '0;
            prev_end_r <= '0;
            lgap_r     <= '0;
          end
        end
        S_SHIFT_WR: j_r <= ins_r ? j_r - 1'b1 : j_r + 1'b1;
        S_INS: begin
          cnt_r      <= cnt_r + 1'b1;
          free_r     <= free_r - req_r.request_size;
          baddr_r    <= clo_r;
          i_r        <= '0;
          prev_end_r <= '0;
          lgap_r     <= '0;
        end
        S_GAP: begin
          if (gap_v > lgap_r) lgap_r <= gap_v;
          prev_end_r <= blk_end;
          i_r        <= i_r + 1'b1;
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_rsp.status        = status_r;
    out_rsp.block_address = baddr_r;
    out_rsp.block_valid   = valid_r;
    out_rsp.block_size    = bsize_r;
    out_rsp.largest_gap   = lgap_r;
    out_rsp.free_bytes    = free_r;
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxBlocks)) else $error("block count overflow");
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= pool_r) else $error("free bytes exceed pool");
  a_gap_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.largest_gap <= out_rsp.free_bytes)
    else $error("largest gap exceeds free bytes");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

endmodule
